// ===== hw/rtl/four_level_page_table_mapper_assert.svh =====
// assertion macros used by the page table mapper datapath
`ifndef FOUR_LEVEL_PAGE_TABLE_MAPPER_ASSERT_SVH
`define FOUR_LEVEL_PAGE_TABLE_MAPPER_ASSERT_SVH

// same-cycle implication, checked on clk and held off during reset
`define FLTPM_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("page table mapper check failed");

// next-cycle implication
`define FLTPM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("page table mapper check failed");

`endif

// ===== hw/rtl/fltpm_pkg.sv =====
// types and constants of the four level page table mapper
package fltpm_pkg;

	localparam int IDX_W   = 9;
	localparam int ENTRIES = 512;
	localparam int FRAME_W = 40;
	localparam int NPEND   = 8;

	localparam logic [1:0] OP_LOOKUP = 2'd0;
	localparam logic [1:0] OP_MAP    = 2'd1;
	localparam logic [1:0] OP_UNMAP  = 2'd2;
	localparam logic [1:0] OP_NONE   = 2'd3;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_WINDOW  = 2'd1;
	localparam logic [1:0] ST_NO_PAGE = 2'd2;

	localparam logic [1:0] CFG_WINDOW_BASE = 2'd0;
	localparam logic [1:0] CFG_ROOT_PAGE   = 2'd1;
	localparam logic [1:0] CFG_FIRST_FREE  = 2'd2;

	localparam logic [1:0] LVL_LEAF = 2'd3;
	localparam logic [1:0] LVL_LAST_LINK = 2'd2;

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_CHECK,
		S_READ,
		S_EVAL,
		S_DECODE,
		S_COMMIT
	} state_t;

	typedef enum logic [2:0] {
		RES_NONE,
		RES_ERR_WINDOW,
		RES_ERR_NO_PAGE,
		RES_PEEK,
		RES_COMMIT
	} res_t;

	typedef struct packed {
		logic init_step;
		logic load;
		logic rd;
		logic eval;
		logic decode;
		logic push_leaf;
		logic commit_step;
		logic fin;
		res_t res;
	} dp_cmd_t;

	typedef struct packed {
		logic       init_last;
		logic       op_bad;
		logic       root_bad;
		logic       alloc_need;
		logic       no_page;
		logic       off_bad;
		logic       commit_done;
		logic       is_lookup;
		logic [1:0] lvl;
	} dp_status_t;

endpackage

// ===== hw/rtl/four_level_page_table_mapper.sv =====
// map and unmap end by committing their pending writes; each new table has all 512 entries cleared
// throughput: one request at a time, the next start is taken in the cycle the result strobes
// each link level of the walk passes through the read, evaluate and decode states; a lookup ends on the leaf evaluate
// reset: the table store is swept to zero while busy is high
// results show for one cycle on done; the receiver cannot stall
module four_level_page_table_mapper #(
	parameter int TABLE_PAGES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  op,
	input  logic [47:0] virt_addr,
	input  logic [51:0] phys_addr,
	input  logic [63:0] entry_flags,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [39:0] cfg_data,
	output logic        done,
	output logic [63:0] entry,
	output logic [1:0]  status,
	output logic        invalidate
);

	fltpm_pkg::dp_cmd_t    cmd;
	fltpm_pkg::dp_status_t st;

	fltpm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.st     (st),
		.cmd    (cmd)
	);

	fltpm_dp #(
		.TABLE_PAGES (TABLE_PAGES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.st          (st),
		.op          (op),
		.virt_addr   (virt_addr),
		.phys_addr   (phys_addr),
		.entry_flags (entry_flags),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.done        (done),
		.entry       (entry),
		.status      (status),
		.invalidate  (invalidate)
	);

endmodule

// ===== hw/rtl/fltpm_ctrl.sv =====
// controller state machine of the page table mapper
module fltpm_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  fltpm_pkg::dp_status_t st,
	output fltpm_pkg::dp_cmd_t    cmd
);

	fltpm_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fltpm_pkg::S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			fltpm_pkg::S_INIT: begin
				cmd.init_step = 1'b1;
				if (st.init_last) begin
					state_d = fltpm_pkg::S_IDLE;
				end
			end
			fltpm_pkg::S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = fltpm_pkg::S_CHECK;
				end
			end
			fltpm_pkg::S_CHECK: begin
				if (st.op_bad) begin
					cmd.fin = 1'b1;
					cmd.res = fltpm_pkg::RES_NONE;
					state_d = fltpm_pkg::S_IDLE;
				end else if (st.root_bad) begin
					cmd.fin = 1'b1;
					cmd.res = fltpm_pkg::RES_ERR_WINDOW;
					state_d = fltpm_pkg::S_IDLE;
				end else begin
					state_d = fltpm_pkg::S_READ;
				end
			end
			fltpm_pkg::S_READ: begin
				cmd.rd  = 1'b1;
				state_d = fltpm_pkg::S_EVAL;
			end
			fltpm_pkg::S_EVAL: begin
				if (st.lvl == fltpm_pkg::LVL_LEAF) begin
					cmd.fin = 1'b1;
					cmd.res = fltpm_pkg::RES_PEEK;
					state_d = fltpm_pkg::S_IDLE;
				end else if (st.alloc_need && st.no_page) begin
					cmd.fin = 1'b1;
					cmd.res = fltpm_pkg::RES_ERR_NO_PAGE;
					state_d = fltpm_pkg::S_IDLE;
				end else begin
					cmd.eval = 1'b1;
					state_d  = fltpm_pkg::S_DECODE;
				end
			end
			fltpm_pkg::S_DECODE: begin
				if (st.off_bad) begin
					cmd.fin = 1'b1;
					cmd.res = fltpm_pkg::RES_ERR_WINDOW;
					state_d = fltpm_pkg::S_IDLE;
				end else begin
					cmd.decode = 1'b1;
					if (st.lvl == fltpm_pkg::LVL_LAST_LINK && !st.is_lookup) begin
						cmd.push_leaf = 1'b1;
						state_d       = fltpm_pkg::S_COMMIT;
					end else begin
						state_d = fltpm_pkg::S_READ;
					end
				end
			end
			fltpm_pkg::S_COMMIT: begin
				if (st.commit_done) begin
					cmd.fin = 1'b1;
					cmd.res = fltpm_pkg::RES_COMMIT;
					state_d = fltpm_pkg::S_IDLE;
				end else begin
					cmd.commit_step = 1'b1;
				end
			end
			default: begin
				state_d = fltpm_pkg::S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != fltpm_pkg::S_IDLE);

endmodule

// ===== hw/rtl/fltpm_dp.sv =====
// datapath of the page table mapper: table store, pending writes, walk registers
`include "four_level_page_table_mapper_assert.svh"

module fltpm_dp #(
	parameter int TABLE_PAGES = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  fltpm_pkg::dp_cmd_t    cmd,
	output fltpm_pkg::dp_status_t st,
	input  logic [1:0]            op,
	input  logic [47:0]           virt_addr,
	input  logic [51:0]           phys_addr,
	input  logic [63:0]           entry_flags,
	input  logic                  cfg_wr_en,
	input  logic [1:0]            cfg_index,
	input  logic [39:0]           cfg_data,
	output logic                  done,
	output logic [63:0]           entry,
	output logic [1:0]            status,
	output logic                  invalidate
);

	localparam int PW    = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
	localparam int AW    = PW + fltpm_pkg::IDX_W;
	localparam int DEPTH = TABLE_PAGES * fltpm_pkg::ENTRIES;

	logic [63:0] mem_q [DEPTH];
	logic [63:0] rd_data_q;

	logic [39:0] wbf_q;
	logic [5:0]  root_q;
	logic [6:0]  next_free_q;

	logic [1:0]  op_q;
	logic [47:0] va_q;
	logic [51:0] pa_q;
	logic [63:0] flags_q;

	logic [PW-1:0] page_q;
	logic [1:0]    lvl_q;
	logic [6:0]    n_q;
	logic [63:0]   entry_q;

	logic                        pend_clr_q  [fltpm_pkg::NPEND];
	logic [PW-1:0]               pend_page_q [fltpm_pkg::NPEND];
	logic [fltpm_pkg::IDX_W-1:0] pend_idx_q  [fltpm_pkg::NPEND];
	logic [63:0]                 pend_val_q  [fltpm_pkg::NPEND];
	logic [2:0]                  pend_n_q;
	logic [2:0]                  ci_q;
	logic [fltpm_pkg::IDX_W-1:0] cnt_q;
	logic [AW-1:0]               init_addr_q;

	logic                        done_q;
	logic [63:0]                 entry_q_out;
	logic [1:0]                  status_q;
	logic                        inval_q;

	logic [fltpm_pkg::IDX_W-1:0] idx_cur;
	logic [63:0]                 peek_val;
	logic [63:0]                 link_val;
	logic [63:0]                 leaf_val;
	logic [39:0]                 off;
	logic                        we;
	logic [AW-1:0]               wa;
	logic [63:0]                 wd;
	logic [AW-1:0]               ra;

	always_comb begin
		unique case (lvl_q)
			2'd0: idx_cur = va_q[47:39];
			2'd1: idx_cur = va_q[38:30];
			2'd2: idx_cur = va_q[29:21];
			2'd3: idx_cur = va_q[20:12];
		endcase
	end

	// later pending events win, a page clear hides older writes to that page
	always_comb begin
		peek_val = rd_data_q;
		for (int i = 0; i < fltpm_pkg::NPEND; i++) begin
			if (3'(i) < pend_n_q && pend_page_q[i] == page_q) begin
				if (pend_clr_q[i]) begin
					peek_val = '0;
				end else if (pend_idx_q[i] == idx_cur) begin
					peek_val = pend_val_q[i];
				end
			end
		end
	end

	assign link_val = {12'd0, wbf_q + {33'd0, n_q}, 12'd0} | flags_q;
	assign leaf_val = (op_q == fltpm_pkg::OP_MAP) ? ({12'd0, pa_q[51:12], 12'd0} | flags_q)
		: 64'd0;
	assign off = entry_q[51:12] - wbf_q;
	assign ra  = {page_q, idx_cur};

	always_comb begin
		st.init_last   = &init_addr_q;
		st.op_bad      = (op_q == fltpm_pkg::OP_NONE);
		st.root_bad    = {26'd0, root_q} >= 32'(TABLE_PAGES);
		st.alloc_need  = (op_q == fltpm_pkg::OP_MAP) && !peek_val[0];
		st.no_page     = {25'd0, n_q} >= 32'(TABLE_PAGES);
		st.off_bad     = off >= 40'(TABLE_PAGES);
		st.commit_done = (ci_q == pend_n_q);
		st.is_lookup   = (op_q == fltpm_pkg::OP_LOOKUP);
		st.lvl         = lvl_q;
	end

	always_comb begin
		we = 1'b0;
		wa = init_addr_q;
		wd = '0;
		if (cmd.init_step) begin
			we = 1'b1;
		end else if (cmd.commit_step) begin
			we = 1'b1;
			if (pend_clr_q[ci_q]) begin
				wa = {pend_page_q[ci_q], cnt_q};
			end else begin
				wa = {pend_page_q[ci_q], pend_idx_q[ci_q]};
				wd = pend_val_q[ci_q];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wa] <= wd;
		end
		if (cmd.rd) begin
			rd_data_q <= mem_q[ra];
		end
	end

	// request and walk payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= op;
			va_q    <= virt_addr;
			pa_q    <= phys_addr;
			flags_q <= entry_flags;
		end
		if (cmd.eval) begin
			entry_q <= st.alloc_need ? link_val : peek_val;
		end
		if (cmd.eval && st.alloc_need) begin
			pend_clr_q[pend_n_q]         <= 1'b1;
			pend_page_q[pend_n_q]        <= PW'({25'd0, n_q});
			pend_idx_q[pend_n_q]         <= '0;
			pend_val_q[pend_n_q]         <= '0;
			pend_clr_q[pend_n_q + 3'd1]  <= 1'b0;
			pend_page_q[pend_n_q + 3'd1] <= page_q;
			pend_idx_q[pend_n_q + 3'd1]  <= idx_cur;
			pend_val_q[pend_n_q + 3'd1]  <= link_val;
		end
		if (cmd.push_leaf) begin
			pend_clr_q[pend_n_q]  <= 1'b0;
			pend_page_q[pend_n_q] <= off[PW-1:0];
			pend_idx_q[pend_n_q]  <= va_q[20:12];
			pend_val_q[pend_n_q]  <= leaf_val;
		end
		if (cmd.fin) begin
			unique case (cmd.res)
				fltpm_pkg::RES_PEEK:   entry_q_out <= peek_val;
				fltpm_pkg::RES_COMMIT: entry_q_out <= leaf_val;
				default:               entry_q_out <= '0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wbf_q       <= '0;
			root_q      <= '0;
			next_free_q <= 7'd1;
			page_q      <= '0;
			lvl_q       <= '0;
			n_q         <= '0;
			pend_n_q    <= '0;
			ci_q        <= '0;
			cnt_q       <= '0;
			init_addr_q <= '0;
			done_q      <= 1'b0;
			status_q    <= fltpm_pkg::ST_OK;
			inval_q     <= 1'b0;
		end else begin
			done_q <= cmd.fin;
			if (cmd.init_step) begin
				init_addr_q <= init_addr_q + AW'(1);
			end
			if (cmd.load) begin
				page_q   <= PW'({26'd0, root_q});
				lvl_q    <= '0;
				n_q      <= next_free_q;
				pend_n_q <= '0;
				ci_q     <= '0;
				cnt_q    <= '0;
			end
			if (cmd.eval && st.alloc_need) begin
				pend_n_q <= pend_n_q + 3'd2;
				n_q      <= n_q + 7'd1;
			end
			if (cmd.decode) begin
				page_q <= off[PW-1:0];
				lvl_q  <= lvl_q + 2'd1;
			end
			if (cmd.push_leaf) begin
				pend_n_q <= pend_n_q + 3'd1;
			end
			if (cmd.commit_step) begin
				if (pend_clr_q[ci_q]) begin
					cnt_q <= cnt_q + 9'd1;
					if (&cnt_q) begin
						ci_q <= ci_q + 3'd1;
					end
				end else begin
					ci_q <= ci_q + 3'd1;
				end
			end
			if (cmd.fin) begin
				inval_q <= (cmd.res == fltpm_pkg::RES_COMMIT);
				unique case (cmd.res)
					fltpm_pkg::RES_ERR_WINDOW:  status_q <= fltpm_pkg::ST_WINDOW;
					fltpm_pkg::RES_ERR_NO_PAGE: status_q <= fltpm_pkg::ST_NO_PAGE;
					default:                    status_q <= fltpm_pkg::ST_OK;
				endcase
				if (cmd.res == fltpm_pkg::RES_COMMIT) begin
					next_free_q <= n_q;
				end
			end
			if (cfg_wr_en) begin
				if (cfg_index == fltpm_pkg::CFG_WINDOW_BASE) begin
					wbf_q <= cfg_data;
				end else if (cfg_index == fltpm_pkg::CFG_ROOT_PAGE) begin
					root_q <= cfg_data[5:0];
				end else if (cfg_index == fltpm_pkg::CFG_FIRST_FREE) begin
					next_free_q <= cfg_data[6:0];
				end
			end
		end
	end

	assign done       = done_q;
	assign entry      = entry_q_out;
	assign status     = status_q;
	assign invalidate = inval_q;

	`FLTPM_ASSERT_NEXT(a_single_strobe, done_q, !done_q)
	`FLTPM_ASSERT_NOW(a_inval_ok, done_q && inval_q, status_q == fltpm_pkg::ST_OK)
	`FLTPM_ASSERT_NOW(a_err_zero, done_q && status_q != fltpm_pkg::ST_OK, entry_q_out == 64'd0)
	`FLTPM_ASSERT_NOW(a_commit_bound, cmd.commit_step, ci_q < pend_n_q)

endmodule

// ===== dv/four_level_page_table_mapper_tb.sv =====
// testbench for the four level page table mapper: directed table, random walks, scoreboard
module four_level_page_table_mapper_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int PAGES = 64;
	localparam int PHASE_ITEMS = 300;

	typedef struct packed {
		logic [63:0] entry;
		logic [1:0]  status;
		logic        inval;
	} walk_res_t;

	typedef struct {
		bit          clr;
		int          page;
		int          idx;
		logic [63:0] val;
	} tbl_write_t;

	typedef struct {
		logic [1:0]  op;
		logic [47:0] va;
		logic [51:0] pa;
		logic [63:0] flags;
		bit          fixed;
		walk_res_t   res;
	} vec_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  op = fltpm_pkg::OP_LOOKUP;
	logic [47:0] virt_addr = '0;
	logic [51:0] phys_addr = '0;
	logic [63:0] entry_flags = '0;
	logic        cfg_wr_en = 1'b0;
	logic [1:0]  cfg_index = fltpm_pkg::CFG_WINDOW_BASE;
	logic [39:0] cfg_data = '0;
	logic        done;
	logic [63:0] entry;
	logic [1:0]  status;
	logic        invalidate;

	four_level_page_table_mapper #(.TABLE_PAGES(PAGES)) dut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// shadow of the table store and its registers
	logic [63:0] shadow_tbl [0:PAGES*fltpm_pkg::ENTRIES-1];
	tbl_write_t  walk_writes [$];
	logic [39:0] win_base;
	int          root_pg;
	int          free_pg;
	walk_res_t   expected_q [$];
	int          errors = 0;
	int          sent = 0;
	logic [47:0] va_pool [8];

	function automatic logic [63:0] peek_entry(int pg, int idx);
		for (int i = walk_writes.size() - 1; i >= 0; i--)
			if (walk_writes[i].page == pg) begin
				if (walk_writes[i].clr)
					return '0;
				if (walk_writes[i].idx == idx)
					return walk_writes[i].val;
			end
		return shadow_tbl[pg*fltpm_pkg::ENTRIES + idx];
	endfunction

	function automatic bit page_of(logic [63:0] e, output int pg);
		logic [39:0] off;
		off = e[51:12] - win_base;
		pg = int'(off[6:0]);
		return off < 40'(PAGES);
	endfunction

	function automatic walk_res_t translate(logic [1:0] o, logic [47:0] va, logic [51:0] pa,
			logic [63:0] flags);
		walk_res_t r;
		int pg, nxt, idx;
		logic [63:0] e;
		logic [39:0] fr;
		r = '{entry: '0, status: fltpm_pkg::ST_OK, inval: 1'b0};
		walk_writes.delete();
		if (o == fltpm_pkg::OP_NONE)
			return r;
		pg = root_pg;
		nxt = free_pg;
		for (int lvl = 0; lvl < 3 && r.status == fltpm_pkg::ST_OK; lvl++) begin
			idx = int'(va[47 - 9*lvl -: 9]);
			e = peek_entry(pg, idx);
			if (o == fltpm_pkg::OP_MAP && !e[0]) begin
				if (nxt >= PAGES) begin
					r.status = fltpm_pkg::ST_NO_PAGE;
					break;
				end
				fr = win_base + 40'(nxt);
				walk_writes.push_back('{1'b1, nxt, 0, '0});
				e = {12'b0, fr, 12'b0} | flags;
				walk_writes.push_back('{1'b0, pg, idx, e});
				nxt++;
			end
			if (!page_of(e, pg))
				r.status = fltpm_pkg::ST_WINDOW;
		end
		if (r.status != fltpm_pkg::ST_OK)
			return r;
		idx = int'(va[20:12]);
		if (o == fltpm_pkg::OP_LOOKUP)
			r.entry = peek_entry(pg, idx);
		else begin
			r.entry = (o == fltpm_pkg::OP_MAP) ? ({12'b0, pa[51:12], 12'b0} | flags) : '0;
			walk_writes.push_back('{1'b0, pg, idx, r.entry});
			foreach (walk_writes[i])
				if (walk_writes[i].clr)
					for (int k = 0; k < fltpm_pkg::ENTRIES; k++)
						shadow_tbl[walk_writes[i].page*fltpm_pkg::ENTRIES + k] = '0;
				else
					shadow_tbl[walk_writes[i].page*fltpm_pkg::ENTRIES + walk_writes[i].idx] =
						walk_writes[i].val;
			free_pg = nxt;
			r.inval = 1'b1;
		end
		walk_writes.delete();
		return r;
	endfunction

	task automatic cfg_write(logic [1:0] idx, logic [39:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
		case (idx)
			fltpm_pkg::CFG_WINDOW_BASE: win_base = data;
			fltpm_pkg::CFG_ROOT_PAGE:   root_pg = int'(data[5:0]);
			fltpm_pkg::CFG_FIRST_FREE: begin
				free_pg = int'(data[6:0]);
			end
			default: ;
		endcase
	endtask

	// issue one request, hold start until accepted, then maybe idle
	task automatic send(vec_t v, bit may_idle);
		walk_res_t r;
		start <= 1'b1;
		op <= v.op;
		virt_addr <= v.va;
		phys_addr <= v.pa;
		entry_flags <= v.flags;
		do @(posedge clk); while (busy);
		r = translate(v.op, v.va, v.pa, v.flags);
		if (v.fixed && r != v.res) begin
			$error("directed row %0d: predictor disagrees with typed result", sent);
			errors++;
		end
		expected_q.push_back(v.fixed ? v.res : r);
		sent++;
		if (may_idle && $urandom_range(99) < 9) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic drain();
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic vec_t rand_vec();
		vec_t v;
		int sel;
		v.fixed = 1'b0;
		v.res = '{entry: '0, status: fltpm_pkg::ST_OK, inval: 1'b0};
		sel = $urandom_range(99);
		v.op = sel < 45 ? fltpm_pkg::OP_MAP : sel < 80 ? fltpm_pkg::OP_LOOKUP :
			sel < 95 ? fltpm_pkg::OP_UNMAP : fltpm_pkg::OP_NONE;
		v.va = va_pool[$urandom_range(7)];
		sel = $urandom_range(99);
		if (sel < 20)
			v.va = 48'({$urandom, $urandom});
		else if (sel < 60)
			v.va[20:12] = 9'($urandom);
		v.va[11:0] = 12'($urandom);
		v.pa = 52'({$urandom, $urandom});
		// mostly present flags kept out of the frame field
		if ($urandom_range(99) < 85)
			v.flags = {12'($urandom), 40'b0, 12'($urandom) | 12'h001};
		else
			v.flags = {$urandom, $urandom};
		return v;
	endfunction

	// result checker
	always @(posedge clk) begin
		if (done) begin
			if (expected_q.size() == 0) begin
				$error("unexpected result: entry %h status %0d", entry, status);
				errors++;
			end else begin
				walk_res_t x;
				x = expected_q.pop_front();
				if (entry !== x.entry) begin
					$error("entry expected %h actual %h", x.entry, entry);
					errors++;
				end
				if (status !== x.status) begin
					$error("status expected %0d actual %0d", x.status, status);
					errors++;
				end
				if (invalidate !== x.inval) begin
					$error("invalidate expected %0d actual %0d", x.inval, invalidate);
					errors++;
				end
			end
		end
	end

	initial begin
		#20_000_000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		vec_t rows [$];
		logic [39:0] bases [6];
		int roots [6];
		int firsts [6];
		for (int i = 0; i < PAGES*fltpm_pkg::ENTRIES; i++)
			shadow_tbl[i] = '0;
		win_base = '0;
		root_pg = 0;
		free_pg = 1;

		rows.push_back('{fltpm_pkg::OP_LOOKUP, 48'h0, 52'h0, 64'h0, 1'b1,
			'{64'h0, fltpm_pkg::ST_OK, 1'b0}});
		rows.push_back('{fltpm_pkg::OP_UNMAP, 48'h0, 52'h0, 64'h0, 1'b1,
			'{64'h0, fltpm_pkg::ST_OK, 1'b1}});
		rows.push_back('{fltpm_pkg::OP_NONE, '1, '1, '1, 1'b1,
			'{64'h0, fltpm_pkg::ST_OK, 1'b0}});
		// frame bits in flags send the new link out of the window
		rows.push_back('{fltpm_pkg::OP_MAP, 48'h0, 52'h1000, 64'h0008_0000_0000_0001, 1'b1,
			'{64'h0, fltpm_pkg::ST_WINDOW, 1'b0}});
		rows.push_back('{fltpm_pkg::OP_MAP, 48'h0, 52'h1000, '1, 1'b1,
			'{64'h0, fltpm_pkg::ST_WINDOW, 1'b0}});
		rows.push_back('{fltpm_pkg::OP_MAP, '1, '1, 64'h1, 1'b0,
			'{64'h0, fltpm_pkg::ST_OK, 1'b0}});
		rows.push_back('{fltpm_pkg::OP_LOOKUP, '1, 52'h0, 64'h0, 1'b0,
			'{64'h0, fltpm_pkg::ST_OK, 1'b0}});
		rows.push_back('{fltpm_pkg::OP_MAP, 48'h0, 52'h1000, 64'h3, 1'b0,
			'{64'h0, fltpm_pkg::ST_OK, 1'b0}});
		rows.push_back('{fltpm_pkg::OP_LOOKUP, 48'h0, 52'h0, 64'h0, 1'b0,
			'{64'h0, fltpm_pkg::ST_OK, 1'b0}});
		rows.push_back('{fltpm_pkg::OP_UNMAP, 48'h0, 52'h0, 64'h0, 1'b1,
			'{64'h0, fltpm_pkg::ST_OK, 1'b1}});
		rows.push_back('{fltpm_pkg::OP_LOOKUP, 48'h0, 52'h0, 64'h0, 1'b0,
			'{64'h0, fltpm_pkg::ST_OK, 1'b0}});
		rows.push_back('{fltpm_pkg::OP_MAP, 48'h8000_0000_0000, 52'h8_0000_0000_0000,
			64'hF000_0000_0000_0007, 1'b0, '{64'h0, fltpm_pkg::ST_OK, 1'b0}});
		rows.push_back('{fltpm_pkg::OP_LOOKUP, 48'h8000_0000_0fff, 52'h0, 64'h0, 1'b0,
			'{64'h0, fltpm_pkg::ST_OK, 1'b0}});
		rows.push_back('{fltpm_pkg::OP_UNMAP, '1, 52'h0, 64'h0, 1'b0,
			'{64'h0, fltpm_pkg::ST_OK, 1'b0}});

		bases = '{40'h0, 40'hFF_FFFF_FFFF, 40'($urandom), 40'h1_2345, 40'($urandom), 40'h0};
		roots = '{0, 63, 5, 0, $urandom_range(63), 0};
		firsts = '{1, 0, 60, 64, $urandom_range(64), 1};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);

		foreach (rows[i])
			send(rows[i], 1'b1);
		start <= 1'b0;
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			cfg_write(fltpm_pkg::CFG_WINDOW_BASE, bases[ph]);
			cfg_write(fltpm_pkg::CFG_ROOT_PAGE, 40'(roots[ph]));
			cfg_write(fltpm_pkg::CFG_FIRST_FREE, 40'(firsts[ph]));
			foreach (va_pool[i])
				va_pool[i] = 48'({$urandom, $urandom});
			for (int n = 0; n < PHASE_ITEMS; n++)
				send(rand_vec(), !(ph == 2 && n >= 50 && n < 250));
			start <= 1'b0;
			drain();
		end

		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/fltpm_pkg.sv
hw/rtl/fltpm_ctrl.sv
hw/rtl/fltpm_dp.sv
hw/rtl/four_level_page_table_mapper.sv
dv/four_level_page_table_mapper_tb.sv
